@@ sv/xkc_pkg.sv @@
// Shared constants, codes and types of the repeating-key XOR cipher with XOR tag.
`default_nettype none
package xkc_pkg;

  localparam int KEY_BYTES   = 32;
  localparam int TAG_BYTES   = 16;
  localparam int KEY_WORDS   = 4;
  localparam int KEY_WORD_W  = 64;
  localparam int KEY_IDX_W   = $clog2(KEY_WORDS);
  localparam int PADDR_W     = KEY_IDX_W + 3;
  localparam int POS_W       = $clog2(KEY_BYTES);
  localparam int SLOT_W      = $clog2(TAG_BYTES);
  localparam int FILL_W      = $clog2(TAG_BYTES + 1);
  localparam int COUNT_W     = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QUSED_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_TAG    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;

  localparam logic [1:0] TR_NONE   = 2'd0;
  localparam logic [1:0] TR_STATUS = 2'd1;
  localparam logic [1:0] TR_TAG    = 2'd2;

  typedef struct packed {
    logic               has_data;
    logic [7:0]         data;
    logic [1:0]         trailer;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } rec_t;

  typedef struct packed {
    logic fold;
    logic shift;
    logic clear;
  } tag_ctrl_t;

endpackage
`default_nettype wire

@@ sv/xkc_tag_cell.sv @@
// One tag accumulator byte: folds plaintext in, clears, and shifts towards the output.
`default_nettype none
module xkc_tag_cell
  import xkc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  tag_ctrl_t       ctrl,
  input  wire logic [7:0] fold_byte,
  input  wire logic [7:0] shift_in,
  output logic      [7:0] value,
  output logic      [7:0] folded
);

  logic [7:0] value_r;
  logic [7:0] value_nxt;

  assign value  = value_r;
  assign folded = ctrl.fold ? (value_r ^ fold_byte) : value_r;

  always_comb begin
    if (ctrl.clear) begin
      value_nxt = '0;
    end else if (ctrl.shift) begin
      value_nxt = shift_in;
    end else begin
      value_nxt = folded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else begin
      value_r <= value_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/xkc_win_cell.sv @@
// One delay window byte: takes its neighbour's byte on every decrypt transfer.
`default_nettype none
module xkc_win_cell
  import xkc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire logic [7:0] shift_in,
  output logic      [7:0] value
);

  logic [7:0] value_r;
  logic [7:0] value_nxt;

  assign value     = value_r;
  assign value_nxt = shift ? shift_in : value_r;

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

@@ sv/xkc_out_queue.sv @@
// Small queue of result records between the cipher chain and the output sequencer.
`default_nettype none
module xkc_out_queue
  import xkc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  rec_t      push_rec,
  input  wire logic pop,
  output rec_t      head_rec,
  output logic      not_empty,
  output logic      full
);

  rec_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_nxt;
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  wr_ptr_nxt;
  logic [QUSED_W-1:0] used_r;
  logic [QUSED_W-1:0] used_nxt;

  assign head_rec  = slot_r[rd_ptr_r];
  assign not_empty = (used_r != '0);
  assign full      = (used_r == QUSED_W'(QUEUE_DEPTH));

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    used_nxt   = used_r;
    if (push && !pop) begin
      used_nxt = used_r + 1'b1;
    end else if (pop && !push) begin
      used_nxt = used_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      used_r   <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      used_r   <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule
`default_nettype wire

@@ sv/xor_key_cipher_with_xor_tag_core.sv @@
// Top level of the repeating-key XOR cipher with XOR checksum tag.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid / in_stall        in_op, in_data_byte, in_last_byte
//   out      output     out_valid / out_stall      out_byte, out_kind, out_status,
//                                                  out_message_count, out_end_of_run
//   cfg      input      psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// One input byte is taken per cycle within a message while in_stall is low; each byte
// updates the tag cells, the window cells or both at the edge of its transfer and its
// results leave through a two-record queue. The last byte of an encrypted message
// blocks the input until the 16 tag bytes have left the tag cells, one per output transfer.
// Reset is synchronous and clears the key registers, the counter and all message state.
// A stalled output holds its result; the input is stalled only while the queue is full
// or a tag is being sent.
`default_nettype none
module xor_key_cipher_with_xor_tag_core
  import xkc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_op,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_last_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [7:0]            out_byte,
  output logic      [1:0]            out_kind,
  output logic      [1:0]            out_status,
  output logic      [COUNT_W-1:0]    out_message_count,
  output logic                       out_end_of_run,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [KEY_WORD_W-1:0] pwdata,
  output logic      [KEY_WORD_W-1:0] prdata,
  output logic                       pready
);

  logic [KEY_WORD_W-1:0] key_r [KEY_WORDS];
  logic [KEY_IDX_W-1:0]  cfg_idx;
  logic                  cfg_wr;

  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   pos_nxt;
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  slot_nxt;
  logic [FILL_W-1:0]  fill_r;
  logic [FILL_W-1:0]  fill_nxt;
  logic               in_msg_r;
  logic               in_msg_nxt;
  logic               op_r;
  logic               op_nxt;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] cnt_nxt;
  logic               tag_busy_r;
  logic               tag_busy_nxt;
  logic [SLOT_W-1:0]  tag_idx_r;
  logic [SLOT_W-1:0]  tag_idx_nxt;
  logic               phase_r;
  logic               phase_nxt;

  logic [KEY_BYTES*8-1:0] key_vec;
  logic [7:0]             key_byte;
  logic                   in_fire;
  logic                   out_fire;
  logic                   eff_op;
  logic                   dec;
  logic                   win_full;
  logic                   full_after;
  logic [7:0]             cipher_src;
  logic [7:0]             cipher_res;
  logic [7:0]             plain;
  logic                   do_fold;
  logic                   win_shift;
  logic                   tag_match;
  logic [1:0]             dec_status;
  logic                   inc;

  logic [7:0]      win_val    [TAG_BYTES];
  logic [7:0]      win_in     [TAG_BYTES];
  logic [7:0]      tag_val    [TAG_BYTES];
  logic [7:0]      tag_folded [TAG_BYTES];
  logic [7:0]      tag_in     [TAG_BYTES];
  tag_ctrl_t       tag_ctrl   [TAG_BYTES];
  logic [TAG_BYTES-1:0] byte_eq;

  logic q_push;
  rec_t q_push_rec;
  logic q_pop;
  rec_t head;
  logic q_not_empty;
  logic q_full;
  logic data_phase;
  logic tag_shift;
  logic tag_last;

  // Configuration registers.
  assign cfg_idx = paddr[PADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = key_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      key_r[cfg_idx] <= pwdata;
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_WORDS; i++) begin
      key_vec[i*KEY_WORD_W +: KEY_WORD_W] = key_r[i];
    end
  end

  assign key_byte = key_vec[{pos_r, 3'b000} +: 8];

  // Cipher step on the byte of the current transfer.
  assign in_stall   = q_full || tag_busy_r;
  assign in_fire    = in_valid && !in_stall;
  assign eff_op     = in_msg_r ? op_r : in_op;
  assign dec        = (eff_op == OP_DECRYPT);
  assign win_full   = (fill_r == FILL_W'(TAG_BYTES));
  assign full_after = win_full || (fill_r == FILL_W'(TAG_BYTES - 1));
  assign cipher_src = dec ? win_val[0] : in_data_byte;
  assign cipher_res = cipher_src ^ key_byte;
  assign plain      = dec ? cipher_res : in_data_byte;
  assign do_fold    = in_fire && (!dec || win_full);
  assign win_shift  = in_fire && dec;

  genvar g;
  generate
    for (g = 0; g < TAG_BYTES; g++) begin : g_cells
      if (g == TAG_BYTES - 1) begin : g_end
        assign win_in[g] = in_data_byte;
        assign tag_in[g] = 8'h00;
      end else begin : g_mid
        assign win_in[g] = win_val[g+1];
        assign tag_in[g] = tag_val[g+1];
      end

      assign tag_ctrl[g].fold  = do_fold && (slot_r == SLOT_W'(g));
      assign tag_ctrl[g].shift = tag_shift;
      assign tag_ctrl[g].clear = in_fire && dec && in_last_byte;
      assign byte_eq[g]        = (win_in[g] == tag_folded[g]);

      xkc_win_cell u_win (
        .clk      (clk),
        .shift    (win_shift),
        .shift_in (win_in[g]),
        .value    (win_val[g])
      );

      xkc_tag_cell u_tag (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tag_ctrl[g]),
        .fold_byte (plain),
        .shift_in  (tag_in[g]),
        .value     (tag_val[g]),
        .folded    (tag_folded[g])
      );
    end
  endgenerate

  assign tag_match  = &byte_eq;
  assign dec_status = !full_after ? ST_SHORT : (tag_match ? ST_OK : ST_MISMATCH);
  assign inc        = in_fire && in_last_byte && (!dec || (dec_status == ST_OK));
  assign cnt_nxt    = cnt_r + COUNT_W'(inc);

  always_comb begin
    pos_nxt    = pos_r;
    slot_nxt   = slot_r;
    fill_nxt   = fill_r;
    in_msg_nxt = in_msg_r;
    op_nxt     = op_r;
    if (in_fire) begin
      if (in_last_byte) begin
        pos_nxt    = '0;
        slot_nxt   = '0;
        fill_nxt   = '0;
        in_msg_nxt = 1'b0;
        op_nxt     = OP_ENCRYPT;
      end else begin
        in_msg_nxt = 1'b1;
        op_nxt     = eff_op;
        if (do_fold) begin
          pos_nxt  = (pos_r == POS_W'(KEY_BYTES - 1)) ? '0 : pos_r + 1'b1;
          slot_nxt = (slot_r == SLOT_W'(TAG_BYTES - 1)) ? '0 : slot_r + 1'b1;
        end
        if (dec && !win_full) begin
          fill_nxt = fill_r + 1'b1;
        end
      end
    end
  end

  // Result records.
  assign q_push = in_fire && (!dec || win_full || in_last_byte);

  always_comb begin
    q_push_rec.has_data = !dec || win_full;
    q_push_rec.data     = cipher_res;
    q_push_rec.status   = (dec && in_last_byte) ? dec_status : ST_OK;
    q_push_rec.count    = cnt_nxt;
    if (!in_last_byte) begin
      q_push_rec.trailer = TR_NONE;
    end else if (dec) begin
      q_push_rec.trailer = TR_STATUS;
    end else begin
      q_push_rec.trailer = TR_TAG;
    end
  end

  xkc_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (q_push_rec),
    .pop       (q_pop),
    .head_rec  (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Output sequencer: data transfer first, then the status or the tag transfers.
  assign out_valid  = q_not_empty;
  assign out_fire   = out_valid && !out_stall;
  assign data_phase = head.has_data && !phase_r;
  assign tag_last   = (tag_idx_r == SLOT_W'(TAG_BYTES - 1));
  assign tag_shift  = out_fire && !data_phase && (head.trailer == TR_TAG);

  always_comb begin
    out_message_count = head.count;
    out_byte          = 8'h00;
    out_kind          = KIND_DATA;
    out_status        = ST_OK;
    out_end_of_run    = 1'b0;
    if (data_phase) begin
      out_byte = head.data;
    end else if (head.trailer == TR_TAG) begin
      out_byte       = tag_val[0];
      out_kind       = KIND_TAG;
      out_end_of_run = tag_last;
    end else begin
      out_kind       = KIND_STATUS;
      out_status     = head.status;
      out_end_of_run = 1'b1;
    end
  end

  always_comb begin
    q_pop = 1'b0;
    if (out_fire) begin
      if (data_phase) begin
        q_pop = (head.trailer == TR_NONE);
      end else if (head.trailer == TR_TAG) begin
        q_pop = tag_last;
      end else begin
        q_pop = 1'b1;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (q_pop) begin
      phase_nxt = 1'b0;
    end else if (out_fire && data_phase) begin
      phase_nxt = 1'b1;
    end
  end

  assign tag_idx_nxt  = tag_shift ? (tag_last ? '0 : tag_idx_r + 1'b1) : tag_idx_r;
  assign tag_busy_nxt = (in_fire && !dec && in_last_byte) ||
                        (tag_busy_r && !(tag_shift && tag_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      slot_r     <= '0;
      fill_r     <= '0;
      in_msg_r   <= 1'b0;
      op_r       <= OP_ENCRYPT;
      cnt_r      <= '0;
      tag_busy_r <= 1'b0;
      tag_idx_r  <= '0;
      phase_r    <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      slot_r     <= slot_nxt;
      fill_r     <= fill_nxt;
      in_msg_r   <= in_msg_nxt;
      op_r       <= op_nxt;
      cnt_r      <= cnt_nxt;
      tag_busy_r <= tag_busy_nxt;
      tag_idx_r  <= tag_idx_nxt;
      phase_r    <= phase_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TAG_BYTES))
    else $error("delay window fill count beyond the tag length");

  a_eor_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_run |-> out_kind != KIND_DATA)
    else $error("end of run marked on a data transfer");

  a_tag_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_TAG) |-> tag_busy_r)
    else $error("tag transfer while no tag is being sent");

  a_msg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_byte |=> (fill_r == '0) && (pos_r == '0) && !in_msg_r)
    else $error("message state not cleared after the last byte");

endmodule
`default_nettype wire
